// ----- hw/rtl/cers_pkg.sv -----
// Shared constants, register indexes, phase codes and the result record of the ranging sequencer.
package cers_pkg;

  // code length and derived widths
  localparam int CODE_BITS = 4;
  localparam int CNT_W     = $clog2(CODE_BITS + 1);
  localparam int IDX_W     = $clog2(CODE_BITS);
  localparam int CMP_W     = (CODE_BITS > 4) ? CODE_BITS : 4;

  // field widths
  localparam int EXP_W  = 4;
  localparam int TIME_W = 16;
  localparam int BIT_W  = 10;
  localparam int DIST_W = 17;
  localparam int PH_W   = 3;
  localparam int CFG_W  = 16;
  localparam int IDXR_W = 2;
  localparam int IN_W   = 8;
  localparam int OUT_W  = 48;

  // register reset values
  localparam logic [EXP_W-1:0]  EXP_RST  = 4'b1001;
  localparam logic [TIME_W-1:0] TMO_RST  = 16'd45000;
  localparam logic [BIT_W-1:0]  PER_RST  = 10'd500;
  localparam logic [BIT_W-1:0]  WIN_RST  = 10'd100;

  // register indexes
  localparam logic [IDXR_W-1:0] REG_EXPECTED = 2'd0;
  localparam logic [IDXR_W-1:0] REG_TIMEOUT  = 2'd1;
  localparam logic [IDXR_W-1:0] REG_PERIOD   = 2'd2;
  localparam logic [IDXR_W-1:0] REG_WINDOW   = 2'd3;

  // phase codes
  localparam logic [PH_W-1:0] PH_START     = 3'd0;
  localparam logic [PH_W-1:0] PH_WAIT_ACK  = 3'd1;
  localparam logic [PH_W-1:0] PH_WAIT_ECHO = 3'd2;
  localparam logic [PH_W-1:0] PH_READ_CODE = 3'd3;
  localparam logic [PH_W-1:0] PH_DONE      = 3'd4;

  // distance = t*343/200 as (t*DIST_MULT) >> DIST_SHIFT, exact for 16-bit t
  localparam int DIST_MULT  = 28772926;
  localparam int DIST_SHIFT = 24;
  localparam int MULT_W     = 25;
  localparam int PROD_W     = TIME_W + MULT_W;

  // result record, last field in the lowest bits
  typedef struct packed {
    logic [OUT_W-45:0]  pad;
    logic [PH_W-1:0]    phase;
    logic [DIST_W-1:0]  distance_hundredth_cm;
    logic [TIME_W-1:0]  flight_time;
    logic [3:0]         decoded_code;
    logic               codes_match;
    logic               report_valid;
    logic               burst_enable;
    logic               trigger_out;
  } result_t;

endpackage

// ----- hw/rtl/coded_echo_ranging_sequencer.sv -----
// Top level of the coded echo ranging sequencer: input register, phase logic, result register.
//
// Each input transaction is one microsecond tick carrying the sampled acknowledge, echo-detect
// and code pin levels; each tick produces exactly one result transaction with the pin drives,
// the phase and, on the decode tick, the match flag, code, flight time and distance. The block
// takes one tick per clock cycle unless the result is stalled; each accepted tick passes
// through the input register, then the single-pass phase update into the result register.
// The distance is taken from a product register fed by the captured echo time, which settles
// there well before the code bits can be decoded. Configuration writes take effect at the
// next clock edge and should be made while no tick is in flight.
module coded_echo_ranging_sequencer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [cers_pkg::IN_W-1:0]       in_tdata,   // ack_level, detect_level, code_level
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // trigger_out, burst_enable, report_valid, codes_match, decoded_code[4],
  // flight_time[16], distance_hundredth_cm[17], phase[3]
  output logic [cers_pkg::OUT_W-1:0]      out_tdata,
  input  logic                            cfg_we,
  input  logic [cers_pkg::IDXR_W-1:0]     cfg_index,
  input  logic [cers_pkg::CFG_W-1:0]      cfg_wdata
);

  // configuration
  logic [cers_pkg::EXP_W-1:0]   expected_r;
  logic [cers_pkg::TIME_W-1:0]  timeout_r;
  logic [cers_pkg::BIT_W-1:0]   period_r;
  logic [cers_pkg::BIT_W-1:0]   window_r;

  // stream registers
  logic                         in_valid_r;
  logic                         ack_r, det_r, cod_r;
  logic                         out_valid_r;
  cers_pkg::result_t            res_r, res_nxt;
  logic                         adv, step;

  // sequencer state
  logic [cers_pkg::PH_W-1:0]      phase_r, phase_nxt;
  logic [cers_pkg::TIME_W-1:0]    elapsed_r, elapsed_nxt, elapsed_inc;
  logic [cers_pkg::BIT_W-1:0]     bit_timer_r, bit_timer_nxt, bit_timer_inc;
  logic [cers_pkg::CNT_W-1:0]     bit_count_r, bit_count_nxt;
  logic [cers_pkg::CODE_BITS-1:0] code_bits_r, code_bits_nxt;
  logic [cers_pkg::TIME_W-1:0]    echo_time_r, echo_time_nxt;
  logic                           trigger_r, trigger_nxt;
  logic                           burst_r, burst_nxt;

  // decode and distance
  logic [cers_pkg::CODE_BITS-1:0] code_fix;
  logic [cers_pkg::CMP_W-1:0]     code_ext;
  logic [cers_pkg::IDX_W-1:0]     samp_idx;
  logic [cers_pkg::PROD_W-1:0]    dist_prod;
  logic [cers_pkg::DIST_W-1:0]    dist_r;

  assign adv        = !out_valid_r || out_tready;
  assign in_tready  = !in_valid_r || adv;
  assign step       = in_valid_r && adv;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r;

  // polarity fix: a leading zero means the whole code arrived inverted
  assign code_fix = code_bits_r[cers_pkg::CODE_BITS-1] ? code_bits_r : ~code_bits_r;
  assign code_ext = cers_pkg::CMP_W'(code_fix);
  assign samp_idx = cers_pkg::IDX_W'(cers_pkg::CODE_BITS - 1)
                    - bit_count_r[cers_pkg::IDX_W-1:0];

  assign elapsed_inc   = (elapsed_r != '1) ? elapsed_r + 1'b1 : elapsed_r;
  assign bit_timer_inc = (bit_timer_r != '1) ? bit_timer_r + 1'b1 : bit_timer_r;

  assign dist_prod = cers_pkg::PROD_W'(echo_time_r)
                     * cers_pkg::PROD_W'(cers_pkg::DIST_MULT);

  always_comb begin
    phase_nxt     = phase_r;
    elapsed_nxt   = elapsed_r;
    bit_timer_nxt = bit_timer_r;
    bit_count_nxt = bit_count_r;
    code_bits_nxt = code_bits_r;
    echo_time_nxt = echo_time_r;
    trigger_nxt   = trigger_r;
    burst_nxt     = burst_r;
    res_nxt       = '0;

    if (phase_r inside {[cers_pkg::PH_WAIT_ACK:cers_pkg::PH_DONE]}) begin
      elapsed_nxt = elapsed_inc;
      if (phase_r == cers_pkg::PH_READ_CODE) begin
        bit_timer_nxt = bit_timer_inc;
      end
      if (elapsed_inc >= timeout_r) begin
        phase_nxt = cers_pkg::PH_START;
        burst_nxt = 1'b0;
      end else begin
        case (phase_r)
          cers_pkg::PH_WAIT_ACK: begin
            if (ack_r) begin
              trigger_nxt = 1'b0;
              phase_nxt   = cers_pkg::PH_WAIT_ECHO;
            end
          end
          cers_pkg::PH_WAIT_ECHO: begin
            if (det_r) begin
              phase_nxt     = cers_pkg::PH_READ_CODE;
              burst_nxt     = 1'b1;
              echo_time_nxt = elapsed_inc;
              bit_timer_nxt = '0;
            end
          end
          cers_pkg::PH_READ_CODE: begin
            if (bit_count_r >= cers_pkg::CNT_W'(cers_pkg::CODE_BITS)) begin
              burst_nxt                     = 1'b0;
              phase_nxt                     = cers_pkg::PH_DONE;
              res_nxt.report_valid          = 1'b1;
              res_nxt.codes_match           = (code_ext == cers_pkg::CMP_W'(expected_r));
              res_nxt.decoded_code          = code_ext[3:0];
              res_nxt.flight_time           = echo_time_r;
              res_nxt.distance_hundredth_cm = dist_r;
            end else if (bit_timer_inc >= period_r) begin
              bit_count_nxt = bit_count_r + 1'b1;
              bit_timer_nxt = '0;
            end else if (bit_timer_inc <= window_r) begin
              code_bits_nxt[samp_idx] = cod_r;
            end
          end
          default: begin
            // done: hold until the timeout restarts the cycle
          end
        endcase
      end
    end else begin
      // start phase, and unused codes behave the same
      elapsed_nxt   = '0;
      bit_timer_nxt = '0;
      bit_count_nxt = '0;
      code_bits_nxt = '0;
      trigger_nxt   = 1'b1;
      burst_nxt     = 1'b0;
      phase_nxt     = cers_pkg::PH_WAIT_ACK;
    end

    res_nxt.trigger_out  = trigger_nxt;
    res_nxt.burst_enable = burst_nxt;
    res_nxt.phase        = phase_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_r <= cers_pkg::EXP_RST;
      timeout_r  <= cers_pkg::TMO_RST;
      period_r   <= cers_pkg::PER_RST;
      window_r   <= cers_pkg::WIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        cers_pkg::REG_EXPECTED: expected_r <= cfg_wdata[cers_pkg::EXP_W-1:0];
        cers_pkg::REG_TIMEOUT:  timeout_r  <= cfg_wdata[cers_pkg::TIME_W-1:0];
        cers_pkg::REG_PERIOD:   period_r   <= cfg_wdata[cers_pkg::BIT_W-1:0];
        cers_pkg::REG_WINDOW:   window_r   <= cfg_wdata[cers_pkg::BIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (adv) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      ack_r <= in_tdata[0];
      det_r <= in_tdata[1];
      cod_r <= in_tdata[2];
    end
    if (step) begin
      res_r <= res_nxt;
    end
    dist_r <= dist_prod[cers_pkg::DIST_SHIFT +: cers_pkg::DIST_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= cers_pkg::PH_START;
      elapsed_r   <= '0;
      bit_timer_r <= '0;
      bit_count_r <= '0;
      code_bits_r <= '0;
      echo_time_r <= '0;
      trigger_r   <= 1'b0;
      burst_r     <= 1'b0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      elapsed_r   <= elapsed_nxt;
      bit_timer_r <= bit_timer_nxt;
      bit_count_r <= bit_count_nxt;
      code_bits_r <= code_bits_nxt;
      echo_time_r <= echo_time_nxt;
      trigger_r   <= trigger_nxt;
      burst_r     <= burst_nxt;
    end
  end

endmodule

// ----- hw/rtl/cers_checker.sv -----
// Port-level checks on the result stream of the ranging sequencer, bound to the top level.
module cers_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [cers_pkg::OUT_W-1:0] out_tdata
);

  cers_pkg::result_t res;
  assign res = out_tdata;

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_report_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.report_valid |-> res.phase == cers_pkg::PH_DONE)
    else $error("report outside done phase");

  a_report_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !res.report_valid |-> !res.codes_match && res.decoded_code == '0
      && res.flight_time == '0 && res.distance_hundredth_cm == '0)
    else $error("report fields set without report");

  // burst runs exactly while the code is being read
  a_burst_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> res.burst_enable == (res.phase == cers_pkg::PH_READ_CODE))
    else $error("burst enable out of phase");

  a_trigger_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (res.phase == cers_pkg::PH_WAIT_ECHO || res.phase == cers_pkg::PH_READ_CODE
      || res.phase == cers_pkg::PH_DONE) |-> !res.trigger_out)
    else $error("trigger still high after acknowledge");

endmodule

bind coded_echo_ranging_sequencer cers_checker u_cers_checker (.*);
